// ===== sv/periodic_note_event_scheduler_macros.svh =====
`ifndef PERIODIC_NOTE_EVENT_SCHEDULER_MACROS_SVH
`define PERIODIC_NOTE_EVENT_SCHEDULER_MACROS_SVH

// same-cycle implication, checked on clk with arst_n as reset
`define PNES_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PNES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pnes_pkg.sv =====
`timescale 1ns / 1ps
package pnes_pkg;

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_ALLOFF = 2'd2;

	localparam logic [1:0] EV_OFF    = 2'd0;
	localparam logic [1:0] EV_ON     = 2'd1;
	localparam logic [1:0] EV_ALLOFF = 2'd2;

	localparam logic [6:0] NOTE_ON_VEL   = 7'd100;
	localparam int         MIDI_CHANNELS = 16;
	localparam int         PERIOD_W      = 32;
	localparam int         COUNT_W       = 48;

endpackage

// ===== sv/periodic_note_event_scheduler.sv =====
`timescale 1ns / 1ps
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+---------------------------------------
// command   | in        | start high, busy low      | action, slot_index, note_* fields
// event     | out       | event_strobe, one cycle   | event_kind/channel/pitch/velocity/sample,
//           |           |                           | last_event
//
// tick: busy through the off pass, a gap state, the on pass and a flush state, one slot table
// read-modify-write per cycle in each pass; the last event leaves in the cycle after the flush
// state, when busy is already low. write: an inactive slot is written from idle without going
// busy; else the bit-serial remainder unit runs at most once for the on and once for the off
// time. all-off: one event per MIDI channel. reset clears the counter and the slot valid bits;
// a slot never written reads as all zero. events cannot be stalled by the receiver.
`include "periodic_note_event_scheduler_macros.svh"
module periodic_note_event_scheduler #(
	parameter int NOTE_SLOTS    = 16,
	parameter int FRACTION_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [3:0]  slot_index,
	input  logic [3:0]  note_channel,
	input  logic [6:0]  note_pitch,
	input  logic [31:0] note_period,
	input  logic [31:0] note_offset,
	input  logic [31:0] note_length,
	output logic        event_strobe,
	output logic [1:0]  event_kind,
	output logic [3:0]  event_channel,
	output logic [6:0]  event_pitch,
	output logic [6:0]  event_velocity,
	output logic [47:0] event_sample,
	output logic        last_event
);
	import pnes_pkg::*;

	localparam int TW = COUNT_W + FRACTION_BITS;
	localparam int AW = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
	localparam logic [PERIOD_W-1:0] ONE_SAMPLE = PERIOD_W'(1) << FRACTION_BITS;

	typedef struct packed {
		logic [3:0]          channel;
		logic [6:0]          pitch;
		logic [PERIOD_W-1:0] period;
		logic [TW-1:0]       on_time;
		logic [TW-1:0]       off_time;
	} slot_t;

	localparam int SW = $bits(slot_t);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_OFF     = 8'b0000_0010,
		S_GAP     = 8'b0000_0100,
		S_ON      = 8'b0000_1000,
		S_FLUSH   = 8'b0001_0000,
		S_WLAUNCH = 8'b0010_0000,
		S_WWAIT   = 8'b0100_0000,
		S_ALLOFF  = 8'b1000_0000
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        slot_q;
	logic [COUNT_W-1:0]   sample_q;
	logic [NOTE_SLOTS-1:0] vld_q;
	logic                 rdv_s1;
	logic                 pend_vld_q;
	logic [1:0]           pend_kind_q;
	logic [3:0]           pend_ch_q;
	logic [6:0]           pend_pitch_q;
	logic                 wphase_q;
	logic [3:0]           ch_cnt_q;
	logic [AW-1:0]        widx_q;
	logic [3:0]           wch_q;
	logic [6:0]           wpitch_q;
	logic [PERIOD_W-1:0]  per_q;
	logic [PERIOD_W:0]    base_on_q;
	logic [PERIOD_W:0]    base_off_q;
	logic [TW-1:0]        on_q;

	logic                 event_strobe_q;
	logic [1:0]           event_kind_q;
	logic [3:0]           event_channel_q;
	logic [6:0]           event_pitch_q;
	logic [6:0]           event_velocity_q;
	logic [COUNT_W-1:0]   event_sample_q;
	logic                 last_event_q;

	logic                 accept;
	logic                 slot_last;
	logic                 slot_in_range;
	logic [PERIOD_W-1:0]  per_in;
	logic [TW-1:0]        now;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	slot_t                ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [SW-1:0]        ram_rdata;
	slot_t                ent;
	logic                 pass_on;
	logic [TW-1:0]        ent_time;
	logic [TW-1:0]        ent_next;
	logic                 fire;
	logic [TW-1:0]        base_sel;
	logic                 base_ge;
	logic                 div_start;
	logic                 div_done;
	logic [PERIOD_W-1:0]  div_rem;
	logic                 resolve;
	logic [TW-1:0]        resolved;
	logic                 out_stb;
	logic [1:0]           out_kind;
	logic [3:0]           out_ch;
	logic [6:0]           out_pitch;
	logic                 out_last;
	logic                 tick_end;

	assign busy          = (state_q != S_IDLE);
	assign accept        = start && !busy;
	assign slot_last     = (slot_q == AW'(NOTE_SLOTS - 1));
	assign slot_in_range = (32'(slot_index) < NOTE_SLOTS);
	assign now           = TW'(sample_q) << FRACTION_BITS;

	// a nonzero period shorter than one sample runs at one sample
	assign per_in = (note_period != '0 && note_period < ONE_SAMPLE) ? ONE_SAMPLE : note_period;

	// slot table read for the tick walk
	always_comb begin
		unique case (state_q)
			S_OFF, S_ON: ram_raddr = slot_last ? '0 : slot_q + 1'b1;
			default:     ram_raddr = '0;
		endcase
	end

	assign ent      = rdv_s1 ? slot_t'(ram_rdata) : '0;
	assign pass_on  = (state_q == S_ON);
	assign ent_time = pass_on ? ent.on_time : ent.off_time;
	assign ent_next = ent_time + TW'(ent.period);
	assign fire     = (state_q == S_OFF || state_q == S_ON) && (ent.period != '0)
		&& (ent_time[TW-1:FRACTION_BITS] <= sample_q);

	// placement of a written slot: first base + n*period not before now
	assign base_sel  = wphase_q ? TW'(base_off_q) : TW'(base_on_q);
	assign base_ge   = (base_sel >= now);
	assign div_start = (state_q == S_WLAUNCH) && !base_ge;
	assign resolve   = ((state_q == S_WLAUNCH) && base_ge) || ((state_q == S_WWAIT) && div_done);
	assign resolved  = (state_q == S_WLAUNCH) ? base_sel :
		(div_rem == '0) ? now : now - TW'(div_rem) + TW'(per_q);

	pnes_rem #(
		.DW(TW)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(now - base_sel),
		.divisor (per_q),
		.done    (div_done),
		.rem     (div_rem)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = ent;
		if (state_q == S_IDLE) begin
			// inactive slot: channel and pitch only, times cleared
			ram_we            = accept && action == ACT_WRITE && slot_in_range && per_in == '0;
			ram_waddr         = AW'(slot_index);
			ram_wdata         = '0;
			ram_wdata.channel = note_channel;
			ram_wdata.pitch   = note_pitch;
		end else if (state_q == S_WLAUNCH || state_q == S_WWAIT) begin
			ram_we             = resolve && wphase_q;
			ram_waddr          = widx_q;
			ram_wdata.channel  = wch_q;
			ram_wdata.pitch    = wpitch_q;
			ram_wdata.period   = per_q;
			ram_wdata.on_time  = on_q;
			ram_wdata.off_time = resolved;
		end else begin
			ram_we = fire;
			if (pass_on) begin
				ram_wdata.on_time = ent_next;
			end else begin
				ram_wdata.off_time = ent_next;
			end
		end
	end

	pnes_ram #(
		.WIDTH(SW),
		.DEPTH(NOTE_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// one tick event is held back so that the final one can carry last_event
	always_comb begin
		out_stb   = 1'b0;
		out_kind  = pend_kind_q;
		out_ch    = pend_ch_q;
		out_pitch = pend_pitch_q;
		out_last  = 1'b0;
		priority if (state_q == S_ALLOFF) begin
			out_stb   = 1'b1;
			out_kind  = EV_ALLOFF;
			out_ch    = ch_cnt_q;
			out_pitch = '0;
			out_last  = (ch_cnt_q == 4'(MIDI_CHANNELS - 1));
		end else if (state_q == S_FLUSH) begin
			out_stb  = pend_vld_q;
			out_last = 1'b1;
		end else if (fire) begin
			out_stb = pend_vld_q;
		end else begin
			out_stb = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			slot_q         <= '0;
			sample_q       <= '0;
			vld_q          <= '0;
			rdv_s1         <= 1'b0;
			pend_vld_q     <= 1'b0;
			wphase_q       <= 1'b0;
			ch_cnt_q       <= '0;
			event_strobe_q <= 1'b0;
		end else begin
			rdv_s1         <= vld_q[ram_raddr];
			event_strobe_q <= out_stb;
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (fire) begin
				pend_vld_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						slot_q     <= '0;
						pend_vld_q <= 1'b0;
						wphase_q   <= 1'b0;
						ch_cnt_q   <= '0;
						priority if (action == ACT_TICK) begin
							state_q <= S_OFF;
						end else if (action == ACT_WRITE) begin
							if (slot_in_range && per_in != '0) begin
								state_q <= S_WLAUNCH;
							end
						end else if (action == ACT_ALLOFF) begin
							state_q <= S_ALLOFF;
						end else begin
							// unused action: nothing to do
							state_q <= S_IDLE;
						end
					end
				end
				S_OFF: begin
					if (slot_last) begin
						state_q <= S_GAP;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				S_GAP: begin
					slot_q  <= '0;
					state_q <= S_ON;
				end
				S_ON: begin
					if (slot_last) begin
						state_q <= S_FLUSH;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				S_FLUSH: begin
					pend_vld_q <= 1'b0;
					sample_q   <= sample_q + 1'b1;
					state_q    <= S_IDLE;
				end
				S_WLAUNCH, S_WWAIT: begin
					if (resolve) begin
						wphase_q <= 1'b1;
						state_q  <= wphase_q ? S_IDLE : S_WLAUNCH;
					end else begin
						state_q <= S_WWAIT;
					end
				end
				S_ALLOFF: begin
					ch_cnt_q <= ch_cnt_q + 1'b1;
					if (ch_cnt_q == 4'(MIDI_CHANNELS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			widx_q     <= AW'(slot_index);
			wch_q      <= note_channel;
			wpitch_q   <= note_pitch;
			per_q      <= per_in;
			base_on_q  <= {1'b0, note_offset};
			base_off_q <= {1'b0, note_offset} + {1'b0, note_length};
		end
		if (resolve && !wphase_q) begin
			on_q <= resolved;
		end
		if (fire) begin
			pend_kind_q  <= pass_on ? EV_ON : EV_OFF;
			pend_ch_q    <= ent.channel;
			pend_pitch_q <= ent.pitch;
		end
		event_kind_q     <= out_kind;
		event_channel_q  <= out_ch;
		event_pitch_q    <= out_pitch;
		event_velocity_q <= (out_kind == EV_ON) ? NOTE_ON_VEL : 7'd0;
		event_sample_q   <= sample_q;
		last_event_q     <= out_last;
	end

	assign event_strobe   = event_strobe_q;
	assign event_kind     = event_kind_q;
	assign event_channel  = event_channel_q;
	assign event_pitch    = event_pitch_q;
	assign event_velocity = event_velocity_q;
	assign event_sample   = event_sample_q;
	assign last_event     = last_event_q;

	assign tick_end = event_strobe && last_event && event_kind != EV_ALLOFF;

	`PNES_ASSERT_NEXT(a_tick_busy, accept && action == ACT_TICK, state_q == S_OFF, "tick not started")
	`PNES_ASSERT_NOW(a_div_done_wait, div_done, state_q == S_WWAIT, "stray remainder done")
	`PNES_ASSERT_NOW(a_tick_last, tick_end, $past(state_q) == S_FLUSH, "tick end not from flush")
	`PNES_ASSERT_NOW(a_idle_write, ram_we && state_q == S_IDLE, ram_wdata.period == '0, "idle write")

endmodule

// ===== sv/pnes_ram.sv =====
`timescale 1ns / 1ps
module pnes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/pnes_rem.sv =====
`timescale 1ns / 1ps
// restoring division, one quotient bit per cycle; only the remainder is kept
module pnes_rem #(
	parameter int DW = 56
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [DW-1:0]             dividend,
	input  logic [pnes_pkg::PERIOD_W-1:0] divisor,
	output logic                      done,
	output logic [pnes_pkg::PERIOD_W-1:0] rem
);
	import pnes_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic                run_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [DW-1:0]       dvd_q;
	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   diff;
	logic [PERIOD_W-1:0] rem_nxt;

	always_comb begin
		trial = {rem_q, dvd_q[DW-1]};
		diff  = trial - {1'b0, divisor};
		// divisor fits 32 bits, so a successful subtract leaves a 32-bit remainder
		rem_nxt = (trial >= {1'b0, divisor}) ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (run_q) begin
			rem_q <= rem_nxt;
			dvd_q <= dvd_q << 1;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import pnes_pkg::*;

	localparam int          FRAC       = 8;
	localparam int          SLOTS      = 16;
	localparam logic [1:0]  ACT_UNUSED = 2'd3;
	localparam logic [31:0] ONE_SAMPLE = 32'd1 << FRAC;
	localparam int          NUM_ITEMS  = 260;
	localparam int          CALM_ITEMS = 40;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  ch;
		logic [6:0]  pitch;
		logic [6:0]  vel;
		logic [47:0] sample;
		logic        last;
	} note_event_t;

	class event_scoreboard;
		note_event_t pending_events[$];
		int          mismatches;
		bit [47:0]   count;
		bit [3:0]    slot_ch [SLOTS];
		bit [6:0]    slot_pitch [SLOTS];
		bit [31:0]   slot_per [SLOTS];
		bit [55:0]   on_at [SLOTS];
		bit [55:0]   off_at [SLOTS];

		function bit due(bit [55:0] t);
			return t[55:FRAC] <= count;
		endfunction

		// first base + n*per, n >= 0, that is not before now
		function bit [55:0] place_time(bit [63:0] base, bit [63:0] per, bit [63:0] now);
			bit [63:0] d, n, t;
			if (base >= now || per == 0)
				return base[55:0];
			d = now - base;
			n = d / per + (((d % per) != 0) ? 64'd1 : 64'd0);
			t = base + n * per;
			return t[55:0];
		endfunction

		function void add_event(logic [1:0] kind, logic [3:0] ch, logic [6:0] pitch,
				logic [6:0] vel);
			note_event_t ev;
			ev.kind   = kind;
			ev.ch     = ch;
			ev.pitch  = pitch;
			ev.vel    = vel;
			ev.sample = count;
			ev.last   = 1'b0;
			pending_events.insert(pending_events.size(), ev);
		endfunction

		function void note_item(logic [1:0] act, logic [3:0] slot, logic [3:0] ch,
				logic [6:0] pitch, logic [31:0] per, logic [31:0] off, logic [31:0] len);
			int          i, n0;
			bit [63:0]   now;
			bit [31:0]   eff;
			n0 = pending_events.size();
			case (act)
				ACT_TICK: begin
					for (i = 0; i < SLOTS; i++)
						if (slot_per[i] != 0 && due(off_at[i])) begin
							add_event(EV_OFF, slot_ch[i], slot_pitch[i], 7'd0);
							off_at[i] = off_at[i] + slot_per[i];
						end
					for (i = 0; i < SLOTS; i++)
						if (slot_per[i] != 0 && due(on_at[i])) begin
							add_event(EV_ON, slot_ch[i], slot_pitch[i], NOTE_ON_VEL);
							on_at[i] = on_at[i] + slot_per[i];
						end
					count = count + 48'd1;
				end
				ACT_WRITE: begin
					now = {8'd0, count, 8'd0};
					eff = per;
					if (eff != 0 && eff < ONE_SAMPLE)
						eff = ONE_SAMPLE;
					slot_ch[slot]    = ch;
					slot_pitch[slot] = pitch;
					slot_per[slot]   = eff;
					if (eff == 0) begin
						on_at[slot]  = '0;
						off_at[slot] = '0;
					end else begin
						on_at[slot]  = place_time({32'd0, off}, {32'd0, eff}, now);
						off_at[slot] = place_time({32'd0, off} + {32'd0, len},
							{32'd0, eff}, now);
					end
				end
				ACT_ALLOFF: begin
					for (i = 0; i < MIDI_CHANNELS; i++)
						add_event(EV_ALLOFF, i[3:0], 7'd0, 7'd0);
				end
				default: ;
			endcase
			if (pending_events.size() > n0)
				pending_events[pending_events.size() - 1].last = 1'b1;
		endfunction

		function void check_event(note_event_t got);
			note_event_t want;
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected event: kind %0d ch %0d pitch %0d vel %0d sample %0d last %0d",
						got.kind, got.ch, got.pitch, got.vel, got.sample, got.last);
				return;
			end
			want = pending_events.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("event mismatch at %0t", $realtime);
					$display("  expected kind %0d ch %0d pitch %0d vel %0d sample %0d last %0d",
						want.kind, want.ch, want.pitch, want.vel, want.sample, want.last);
					$display("  actual   kind %0d ch %0d pitch %0d vel %0d sample %0d last %0d",
						got.kind, got.ch, got.pitch, got.vel, got.sample, got.last);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  action = ACT_TICK;
	logic [3:0]  slot_index = '0;
	logic [3:0]  note_channel = '0;
	logic [6:0]  note_pitch = '0;
	logic [31:0] note_period = '0;
	logic [31:0] note_offset = '0;
	logic [31:0] note_length = '0;
	logic        event_strobe;
	logic [1:0]  event_kind;
	logic [3:0]  event_channel;
	logic [6:0]  event_pitch;
	logic [6:0]  event_velocity;
	logic [47:0] event_sample;
	logic        last_event;

	event_scoreboard sb;

	periodic_note_event_scheduler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.slot_index    (slot_index),
		.note_channel  (note_channel),
		.note_pitch    (note_pitch),
		.note_period   (note_period),
		.note_offset   (note_offset),
		.note_length   (note_length),
		.event_strobe  (event_strobe),
		.event_kind    (event_kind),
		.event_channel (event_channel),
		.event_pitch   (event_pitch),
		.event_velocity(event_velocity),
		.event_sample  (event_sample),
		.last_event    (last_event)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && event_strobe)
			sb.check_event({event_kind, event_channel, event_pitch, event_velocity,
				event_sample, last_event});
	end

	// called at a rising edge; returns at the edge that accepts the item, start still high
	task automatic send_item(logic [1:0] act, logic [3:0] slot, logic [3:0] ch,
			logic [6:0] pitch, logic [31:0] per, logic [31:0] off, logic [31:0] len);
		start        <= 1'b1;
		action       <= act;
		slot_index   <= slot;
		note_channel <= ch;
		note_pitch   <= pitch;
		note_period  <= per;
		note_offset  <= off;
		note_length  <= len;
		do @(posedge clk); while (busy);
		sb.note_item(act, slot, ch, pitch, per, off, len);
	endtask

	task automatic tick();
		send_item(ACT_TICK, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			7'($urandom_range(0, 127)), $urandom, $urandom, $urandom);
	endtask

	task automatic maybe_idle(bit allowed);
		if (allowed && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	int          done_items;
	int          pick;
	logic [31:0] per, off, len, now_q;

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		tick();
		send_item(ACT_ALLOFF, 4'd0, 4'd0, 7'd0, 32'd0, 32'd0, 32'd0);
		maybe_idle(1'b1);
		send_item(ACT_UNUSED, 4'd15, 4'd15, 7'd127, '1, '1, '1);
		send_item(ACT_WRITE, 4'd0, 4'd0, 7'd0, 32'd0, 32'd0, 32'd0);
		send_item(ACT_WRITE, 4'd15, 4'd15, 7'd127, 32'd1, 32'd0, 32'd0);
		send_item(ACT_WRITE, 4'd1, 4'd3, 7'd60, 4 * ONE_SAMPLE, 2 * ONE_SAMPLE + 128,
			ONE_SAMPLE + 64);
		maybe_idle(1'b1);
		send_item(ACT_WRITE, 4'd2, 4'd9, 7'd64, '1, '1, '1);
		send_item(ACT_WRITE, 4'd3, 4'd5, 7'd72, ONE_SAMPLE - 1, 3 * ONE_SAMPLE,
			2 * ONE_SAMPLE);
		repeat (6) begin
			tick();
			maybe_idle(1'b1);
		end
		// offset already behind the counter: placement rounds up
		send_item(ACT_WRITE, 4'd4, 4'd1, 7'd40, 3 * ONE_SAMPLE + 17, 32'd0, 32'd100);
		send_item(ACT_WRITE, 4'd5, 4'd2, 7'd50, 5 * ONE_SAMPLE, 2 * ONE_SAMPLE,
			5 * ONE_SAMPLE);
		repeat (5) begin
			tick();
			maybe_idle(1'b1);
		end
		send_item(ACT_ALLOFF, 4'd7, 4'd7, 7'd7, 32'd7, 32'd7, 32'd7);
		send_item(ACT_WRITE, 4'd15, 4'd15, 7'd127, 32'd0, '1, '1);
		tick();

		// random part
		done_items = 0;
		while (done_items < NUM_ITEMS) begin
			pick = $urandom_range(0, 99);
			now_q = sb.count[31:0];
			if (pick < 62) begin
				tick();
			end else if (pick < 82) begin
				per = $urandom_range(ONE_SAMPLE, 24 * ONE_SAMPLE);
				if ($urandom_range(0, 3) == 0)
					off = $urandom_range(0, now_q << FRAC);
				else
					off = ((now_q + $urandom_range(0, 12)) << FRAC) + $urandom_range(0, 255);
				len = $urandom_range(0, 2 * per);
				send_item(ACT_WRITE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					7'($urandom_range(0, 127)), per, off, len);
			end else if (pick < 90) begin
				send_item(ACT_WRITE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					7'($urandom_range(0, 127)), $urandom, $urandom, $urandom);
			end else if (pick < 93) begin
				send_item(ACT_WRITE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					7'($urandom_range(0, 127)), 32'd0, $urandom, $urandom);
			end else if (pick < 96) begin
				send_item(ACT_WRITE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					7'($urandom_range(0, 127)), $urandom_range(1, ONE_SAMPLE - 1),
					(now_q << FRAC) + $urandom_range(0, 1023), $urandom_range(0, 511));
			end else if (pick < 98) begin
				send_item(ACT_ALLOFF, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					7'($urandom_range(0, 127)), $urandom, $urandom, $urandom);
			end else begin
				// unused action, does not count as an item
				send_item(ACT_UNUSED, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					7'($urandom_range(0, 127)), $urandom, $urandom, $urandom);
				done_items--;
			end
			done_items++;

			if (done_items == NUM_ITEMS / 2) begin
				// drain everything before going on
				start <= 1'b0;
				do @(posedge clk); while (sb.pending_events.size() != 0);
			end else begin
				maybe_idle(done_items < NUM_ITEMS - CALM_ITEMS);
			end
		end

		start <= 1'b0;
		while (sb.pending_events.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_events.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

endmodule
